FILE: hw/rtl/particle_swirl_update_top_assert.svh
// assertion macros for the particle swirl update block
// used by the port checker; no other dependencies
`ifndef PARTICLE_SWIRL_UPDATE_TOP_ASSERT_SVH
`define PARTICLE_SWIRL_UPDATE_TOP_ASSERT_SVH

// clocked check, off while reset is held
`define PSU_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also runs during reset
`define PSU_ASSERT_RST(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/psu_pkg.sv
// shared types, constants and saturation helper for the particle swirl update
// no dependencies
package psu_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 29;
    localparam logic [31:0] DIV5_RECIP = 32'hCCCCCCCD;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic [30:0]        elapsed;
        logic [30:0]        lifetime;
    } item_t;

    typedef struct packed {
        logic signed [31:0] new_x;
        logic signed [31:0] new_y;
        logic signed [31:0] new_z;
        logic               saturated;
    } result_t;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic               sat;
        logic               nz;
        logic [2:0]         neg;
        logic [26:0]        k;
        logic [30:0]        ax;
        logic [30:0]        ay;
        logic [30:0]        az;
    } side_t;

    // {clamped, value}
    function automatic logic [32:0] sat_s32(input logic signed [63:0] v);
        logic [32:0] r;
        if (v > 64'sd2147483647)
        begin
            r = {1'b1, 32'h7FFFFFFF};
        end
        else if (v < -64'sd2147483648)
        begin
            r = {1'b1, 32'h80000000};
        end
        else
        begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/psu_integrate.sv
// position integration p + v*dt with saturation, and swirl strength from life
// depends on psu_pkg
module psu_integrate (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           vin,
    input  psu_pkg::item_t din,
    output logic           vout,
    output psu_pkg::side_t sout
);
    import psu_pkg::*;

    localparam logic signed [63:0] ROUND_HALF = 64'sd1 <<< (FRAC_BITS - 1);

    logic signed [63:0] prod_next [3];
    logic signed [63:0] prod_reg  [3];
    logic signed [31:0] pos_reg   [3];
    logic [61:0]        kprod_next;
    logic [61:0]        kprod_reg;
    logic               v1_reg;
    logic               v2_reg;
    side_t              side_next;
    side_t              side_reg;
    logic signed [31:0] dt_s;
    logic [31:0]        lsum;
    logic signed [63:0] acc [3];
    logic [32:0]        st  [3];

    always_comb
    begin
        dt_s         = {1'b0, din.elapsed};
        prod_next[0] = din.vel_x * dt_s;
        prod_next[1] = din.vel_y * dt_s;
        prod_next[2] = din.vel_z * dt_s;
        lsum         = {1'b0, din.lifetime} + 32'd10;
        kprod_next   = lsum[31:2] * DIV5_RECIP;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= vin;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= prod_next;
            pos_reg   <= '{din.pos_x, din.pos_y, din.pos_z};
            kprod_reg <= kprod_next;
            side_reg  <= side_next;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            acc[i] = ((prod_reg[i] + ROUND_HALF) >>> FRAC_BITS) + 64'(pos_reg[i]);
            st[i]  = sat_s32(acc[i]);
        end
        side_next     = '0;
        side_next.px  = st[0][31:0];
        side_next.py  = st[1][31:0];
        side_next.pz  = st[2][31:0];
        side_next.sat = st[0][32] | st[1][32] | st[2][32];
        side_next.k   = kprod_reg[60:34];
    end

    assign vout = v2_reg;
    assign sout = side_reg;

endmodule

FILE: hw/rtl/psu_norm.sv
// swirl vector, magnitude normalization and sum of squares
// depends on psu_pkg
module psu_norm (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           vin,
    input  psu_pkg::side_t sin,
    output logic           vout,
    output psu_pkg::side_t sout,
    output logic [63:0]    sum
);
    import psu_pkg::*;

    logic signed [33:0] px_w, py_w, pz_w;
    logic signed [33:0] t    [3];
    logic signed [33:0] absn [3];
    logic [31:0]        a_next [3];
    logic [31:0]        aa_reg [3];
    side_t              sa_next, sa_reg;
    logic               va_reg;

    logic [31:0]        m;
    logic [4:0]         msb;
    logic [31:0]        ab_reg [3];
    logic               shr_reg;
    logic [4:0]         shl_reg;
    side_t              sb_next, sb_reg;
    logic               vb_reg;

    logic [31:0]        sh [3];
    side_t              sc_next, sc_reg;
    logic               vc_reg;

    logic [61:0]        sq_reg [3];
    side_t              sd_reg;
    logic               vd_reg;

    logic [63:0]        sum_reg;
    side_t              se_reg;
    logic               ve_reg;

    always_comb
    begin
        px_w = {{2{sin.px[31]}}, sin.px};
        py_w = {{2{sin.py[31]}}, sin.py};
        pz_w = {{2{sin.pz[31]}}, sin.pz};
        t[0] = py_w + ((pz_w + 34'sd2) >>> 2);
        t[1] = -px_w;
        t[2] = -((px_w + 34'sd2) >>> 2);
        sa_next = sin;
        for (int i = 0; i < 3; i++)
        begin
            sa_next.neg[i] = t[i][33];
            absn[i]        = t[i][33] ? -t[i] : t[i];
            a_next[i]      = absn[i][31:0];
        end
    end

    always_comb
    begin
        m = aa_reg[0];
        if (aa_reg[1] > m)
        begin
            m = aa_reg[1];
        end
        if (aa_reg[2] > m)
        begin
            m = aa_reg[2];
        end
        msb = '0;
        for (int i = 0; i < 31; i++)
        begin
            if (m[i])
            begin
                msb = 5'(i);
            end
        end
        sb_next    = sa_reg;
        sb_next.nz = |m;
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sh[i] = shr_reg ? (ab_reg[i] >> 1) : (ab_reg[i] << shl_reg);
        end
        sc_next    = sb_reg;
        sc_next.ax = sh[0][30:0];
        sc_next.ay = sh[1][30:0];
        sc_next.az = sh[2][30:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= vin;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
            ve_reg <= vd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            aa_reg  <= a_next;
            sa_reg  <= sa_next;
            ab_reg  <= aa_reg;
            shr_reg <= m[31];
            shl_reg <= 5'd30 - msb;
            sb_reg  <= sb_next;
            sc_reg  <= sc_next;
            sq_reg[0] <= sc_reg.ax * sc_reg.ax;
            sq_reg[1] <= sc_reg.ay * sc_reg.ay;
            sq_reg[2] <= sc_reg.az * sc_reg.az;
            sd_reg  <= sc_reg;
            sum_reg <= 64'(sq_reg[0]) + 64'(sq_reg[1]) + 64'(sq_reg[2]);
            se_reg  <= sd_reg;
        end
    end

    assign vout = ve_reg;
    assign sout = se_reg;
    assign sum  = sum_reg;

endmodule

FILE: hw/rtl/psu_isqrt.sv
// pipelined integer square root, one result bit per stage
// depends on psu_pkg
module psu_isqrt (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           vin,
    input  psu_pkg::side_t sin,
    input  logic [63:0]    sum,
    output logic           vout,
    output psu_pkg::side_t sout,
    output logic [31:0]    mag
);
    import psu_pkg::*;

    logic [63:0] n_reg  [SQRT_STEPS];
    logic [35:0] r_reg  [SQRT_STEPS];
    logic [31:0] q_reg  [SQRT_STEPS];
    logic        v_reg  [SQRT_STEPS];
    side_t       sd_reg [SQRT_STEPS];

    for (genvar j = 0; j < SQRT_STEPS; j++)
    begin : g_step
        logic [63:0] n_src;
        logic [35:0] r_src;
        logic [31:0] q_src;
        logic        v_src;
        side_t       s_src;
        logic [35:0] rr, tr;
        logic        ge;

        if (j == 0)
        begin : g_first
            assign n_src = sum;
            assign r_src = '0;
            assign q_src = '0;
            assign v_src = vin;
            assign s_src = sin;
        end
        else
        begin : g_next
            assign n_src = n_reg[j-1];
            assign r_src = r_reg[j-1];
            assign q_src = q_reg[j-1];
            assign v_src = v_reg[j-1];
            assign s_src = sd_reg[j-1];
        end

        always_comb
        begin
            rr = {r_src[33:0], n_src[63:62]};
            tr = {2'b00, q_src, 2'b01};
            ge = (rr >= tr);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[j] <= v_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[j]  <= {n_src[61:0], 2'b00};
                r_reg[j]  <= ge ? (rr - tr) : rr;
                q_reg[j]  <= {q_src[30:0], ge};
                sd_reg[j] <= s_src;
            end
        end
    end

    assign vout = v_reg[SQRT_STEPS-1];
    assign sout = sd_reg[SQRT_STEPS-1];
    assign mag  = q_reg[SQRT_STEPS-1];

endmodule

FILE: hw/rtl/psu_divide.sv
// scaled direction: (a*k + mag/2) / mag on three lanes, restoring, one bit per stage
// depends on psu_pkg
module psu_divide (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           vin,
    input  psu_pkg::side_t sin,
    input  logic [31:0]    mag,
    output logic           vout,
    output psu_pkg::side_t sout,
    output logic [28:0]    qx,
    output logic [28:0]    qy,
    output logic [28:0]    qz
);
    import psu_pkg::*;

    logic [57:0] prod_reg [3];
    logic [31:0] mag_reg;
    side_t       sm_reg;
    logic        vm_reg;

    logic [58:0] numer [3];
    logic [31:0] r0_reg [3];
    logic [28:0] nb0_reg [3];
    logic [31:0] d0_reg;
    side_t       s0_reg;
    logic        v0_reg;

    logic [31:0] r_reg  [DIV_STEPS][3];
    logic [28:0] nb_reg [DIV_STEPS][3];
    logic [28:0] q_reg  [DIV_STEPS][3];
    logic [31:0] d_reg  [DIV_STEPS];
    logic        v_reg  [DIV_STEPS];
    side_t       sd_reg [DIV_STEPS];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            numer[i] = {1'b0, prod_reg[i]} + 59'(mag_reg[31:1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vm_reg <= 1'b0;
            v0_reg <= 1'b0;
        end
        else if (en)
        begin
            vm_reg <= vin;
            v0_reg <= vm_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg[0] <= sin.ax * sin.k;
            prod_reg[1] <= sin.ay * sin.k;
            prod_reg[2] <= sin.az * sin.k;
            mag_reg     <= mag;
            sm_reg      <= sin;
            for (int i = 0; i < 3; i++)
            begin
                r0_reg[i]  <= {2'b00, numer[i][58:29]};
                nb0_reg[i] <= numer[i][28:0];
            end
            d0_reg <= mag_reg;
            s0_reg <= sm_reg;
        end
    end

    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_step
        logic [31:0] d_src;
        logic        v_src;
        side_t       s_src;

        if (j == 0)
        begin : g_first
            assign d_src = d0_reg;
            assign v_src = v0_reg;
            assign s_src = s0_reg;
        end
        else
        begin : g_next
            assign d_src = d_reg[j-1];
            assign v_src = v_reg[j-1];
            assign s_src = sd_reg[j-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[j] <= v_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_reg[j]  <= d_src;
                sd_reg[j] <= s_src;
            end
        end

        for (genvar l = 0; l < 3; l++)
        begin : g_lane
            logic [31:0] r_src;
            logic [28:0] nb_src;
            logic [28:0] q_src;
            logic [32:0] rr, dd, rn;
            logic        ge;

            if (j == 0)
            begin : g_first
                assign r_src  = r0_reg[l];
                assign nb_src = nb0_reg[l];
                assign q_src  = '0;
            end
            else
            begin : g_next
                assign r_src  = r_reg[j-1][l];
                assign nb_src = nb_reg[j-1][l];
                assign q_src  = q_reg[j-1][l];
            end

            always_comb
            begin
                rr = {r_src, nb_src[28]};
                dd = {1'b0, d_src};
                ge = (rr >= dd);
                rn = ge ? (rr - dd) : rr;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r_reg[j][l]  <= rn[31:0];
                    nb_reg[j][l] <= {nb_src[27:0], 1'b0};
                    q_reg[j][l]  <= {q_src[27:0], ge};
                end
            end
        end
    end

    assign vout = v_reg[DIV_STEPS-1];
    assign sout = sd_reg[DIV_STEPS-1];
    assign qx   = q_reg[DIV_STEPS-1][0];
    assign qy   = q_reg[DIV_STEPS-1][1];
    assign qz   = q_reg[DIV_STEPS-1][2];

endmodule

FILE: hw/rtl/particle_swirl_update_top.sv
// particle swirl update: integration, swirl direction and saturated position output
// depends on psu_pkg, psu_integrate, psu_norm, psu_isqrt, psu_divide
//
// usage:
//   item channel: item_valid / item_stall with payload item (position, velocity,
//   time step, life). a transfer happens when item_valid is high and item_stall low.
//   result channel: result_valid / result_stall with payload result (new position
//   and a saturated flag), one result per item, in item order.
//   pipeline: each item passes the integration and normalization stages, the
//   32-stage square root and the 29-stage restoring divider, and then the result
//   register that drives result_valid.
//   throughput: one item per cycle while the result side takes a transfer each cycle.
//   stall: when a result is held by result_stall, the whole pipeline freezes and
//   item_stall is raised; nothing is dropped or repeated, bubbles are kept.
//   reset: rst_n clears all valid bits; the block takes items from the first
//   cycle after reset is released.
module particle_swirl_update_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  psu_pkg::item_t     item,
    output logic               result_valid,
    input  logic               result_stall,
    output psu_pkg::result_t   result
);
    import psu_pkg::*;

    logic        en;
    logic        v_int, v_nrm, v_sqr, v_div;
    side_t       s_int, s_nrm, s_sqr, s_div;
    logic [63:0] sum;
    logic [31:0] mag;
    logic [28:0] q [3];
    logic        valid_reg;
    result_t     result_reg, result_next;
    logic signed [31:0] p  [3];
    logic signed [63:0] ds [3];
    logic signed [63:0] acc [3];
    logic [32:0]        st [3];

    assign en         = !valid_reg || !result_stall;
    assign item_stall = !en;

    psu_integrate u_int (
        .clk  (clk),
        .rst_n(rst_n),
        .en   (en),
        .vin  (item_valid),
        .din  (item),
        .vout (v_int),
        .sout (s_int)
    );

    psu_norm u_nrm (
        .clk  (clk),
        .rst_n(rst_n),
        .en   (en),
        .vin  (v_int),
        .sin  (s_int),
        .vout (v_nrm),
        .sout (s_nrm),
        .sum  (sum)
    );

    psu_isqrt u_sqr (
        .clk  (clk),
        .rst_n(rst_n),
        .en   (en),
        .vin  (v_nrm),
        .sin  (s_nrm),
        .sum  (sum),
        .vout (v_sqr),
        .sout (s_sqr),
        .mag  (mag)
    );

    psu_divide u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .en   (en),
        .vin  (v_sqr),
        .sin  (s_sqr),
        .mag  (mag),
        .vout (v_div),
        .sout (s_div),
        .qx   (q[0]),
        .qy   (q[1]),
        .qz   (q[2])
    );

    always_comb
    begin
        p[0] = s_div.px;
        p[1] = s_div.py;
        p[2] = s_div.pz;
        for (int i = 0; i < 3; i++)
        begin
            ds[i]  = s_div.neg[i] ? -64'(q[i]) : 64'(q[i]);
            acc[i] = 64'(p[i]) + ds[i];
            st[i]  = s_div.nz ? sat_s32(acc[i]) : {1'b0, p[i]};
        end
        result_next.new_x     = st[0][31:0];
        result_next.new_y     = st[1][31:0];
        result_next.new_z     = st[2][31:0];
        result_next.saturated = s_div.sat | st[0][32] | st[1][32] | st[2][32];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= v_div;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

FILE: hw/rtl/psu_checker.sv
// port checker for the particle swirl update top level, with its bind
// depends on psu_pkg and particle_swirl_update_top_assert.svh
`include "particle_swirl_update_top_assert.svh"

module psu_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_stall,
    input psu_pkg::item_t   item,
    input logic             result_valid,
    input logic             result_stall,
    input psu_pkg::result_t result
);
    import psu_pkg::*;

    `PSU_ASSERT(a_item_hold, item_valid && item_stall |=> item_valid && $stable(item), "stalled item changed")
    `PSU_ASSERT(a_result_hold, result_valid && result_stall |=> result_valid && $stable(result), "stalled result changed")
    `PSU_ASSERT(a_stall_cause, item_stall |-> result_valid && result_stall, "item stalled without a blocked result")
    `PSU_ASSERT(a_flow_on_take, result_valid && !result_stall |-> !item_stall, "item stalled while result transfer proceeds")
    `PSU_ASSERT_RST(a_reset_idle, !rst_n |-> !result_valid, "result valid during reset")

endmodule

bind particle_swirl_update_top psu_checker u_psu_checker (.*);

FILE: bench/particle_swirl_update_top_tb.sv
// testbench for particle_swirl_update_top: directed and random particles, random idling
// depends on psu_pkg and the particle_swirl_update_top rtl
module particle_swirl_update_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import psu_pkg::*;

    localparam int LATENCY = 71;
    localparam int N_RANDOM = 400;
    localparam int CYCLE_LIMIT = 200000;

    class swirl_scoreboard;
        result_t pending[$];
        int errors;

        function new();
            errors = 0;
        endfunction

        static function logic signed [63:0] clamp32(input logic signed [63:0] v, inout bit hit);
            if (v > 64'sd2147483647)
            begin
                hit = 1;
                return 64'sd2147483647;
            end
            if (v < -64'sd2147483648)
            begin
                hit = 1;
                return -64'sd2147483648;
            end
            return v;
        endfunction

        static function logic [63:0] root64(input logic [63:0] n);
            logic [63:0] res;
            logic [63:0] b;
            res = 0;
            b = 64'd1 << 62;
            while (b > n)
                b = b >> 2;
            while (b != 0)
            begin
                if (n >= res + b)
                begin
                    n = n - (res + b);
                    res = (res >> 1) + b;
                end
                else
                    res = res >> 1;
                b = b >> 2;
            end
            return res;
        endfunction

        static function result_t swirl_position(input item_t it);
            logic signed [63:0] p[3];
            logic signed [63:0] t[3];
            logic signed [63:0] vel[3];
            logic signed [63:0] prod;
            logic [63:0] a[3];
            logic [63:0] m;
            logic [63:0] mag;
            logic [63:0] k;
            logic [63:0] d;
            bit hit;
            result_t r;
            hit = 0;
            p[0] = it.pos_x;
            p[1] = it.pos_y;
            p[2] = it.pos_z;
            vel[0] = it.vel_x;
            vel[1] = it.vel_y;
            vel[2] = it.vel_z;
            for (int i = 0; i < 3; i++)
            begin
                prod = vel[i] * $signed({33'd0, it.elapsed}) + (64'sd1 <<< (FRAC_BITS - 1));
                p[i] = clamp32(p[i] + (prod >>> FRAC_BITS), hit);
            end
            t[0] = p[1] + ((p[2] + 2) >>> 2);
            t[1] = -p[0];
            t[2] = -((p[0] + 2) >>> 2);
            m = 0;
            for (int i = 0; i < 3; i++)
            begin
                a[i] = t[i] < 0 ? -t[i] : t[i];
                if (a[i] > m)
                    m = a[i];
            end
            if (m != 0)
            begin
                while (m >= (64'd1 << 31))
                begin
                    m = m >> 1;
                    for (int i = 0; i < 3; i++)
                        a[i] = a[i] >> 1;
                end
                while (m < (64'd1 << 30))
                begin
                    m = m << 1;
                    for (int i = 0; i < 3; i++)
                        a[i] = a[i] << 1;
                end
                mag = root64(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
                k = ({33'd0, it.lifetime} + 10) / 20;
                for (int i = 0; i < 3; i++)
                begin
                    d = (a[i] * k + (mag >> 1)) / mag;
                    p[i] = clamp32(t[i] < 0 ? p[i] - $signed(d) : p[i] + $signed(d), hit);
                end
            end
            r.new_x = p[0][31:0];
            r.new_y = p[1][31:0];
            r.new_z = p[2][31:0];
            r.saturated = hit;
            return r;
        endfunction

        function void note_item(input item_t it);
            pending.push_back(swirl_position(it));
        endfunction

        function void check_result(input result_t got);
            result_t want;
            if (pending.size() == 0)
            begin
                $display("%0t unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.new_x !== want.new_x)
            begin
                $display("%0t new_x expected %h actual %h", $time, want.new_x, got.new_x);
                errors++;
            end
            if (got.new_y !== want.new_y)
            begin
                $display("%0t new_y expected %h actual %h", $time, want.new_y, got.new_y);
                errors++;
            end
            if (got.new_z !== want.new_z)
            begin
                $display("%0t new_z expected %h actual %h", $time, want.new_z, got.new_z);
                errors++;
            end
            if (got.saturated !== want.saturated)
            begin
                $display("%0t saturated expected %b actual %b", $time, want.saturated,
                         got.saturated);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic item_valid;
    logic item_stall;
    item_t item;
    logic result_valid;
    logic result_stall;
    result_t result;

    swirl_scoreboard sb;
    int cycles;
    bit long_holdoff;

    particle_swirl_update_top u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && result_valid && !result_stall)
            sb.check_result(result);

    // receiver: random stall per transfer, one long hold-off on request
    initial
    begin
        int gap;
        result_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (long_holdoff)
            begin
                result_stall <= 1'b1;
                repeat (300) @(negedge clk);
                long_holdoff = 0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
            if (gap == 0)
            begin
                result_stall <= 1'b0;
            end
            else
            begin
                result_stall <= 1'b1;
                repeat (gap - 1) @(negedge clk);
                @(negedge clk);
                result_stall <= 1'b0;
            end
            while (!(result_valid === 1'b1)) @(negedge clk);
            @(posedge clk);
            while (result_stall) @(posedge clk);
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
            3: return 32'd0;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [30:0] rand_half();
        case ($urandom_range(0, 4))
            0: return 31'h7FFFFFFF;
            1: return 31'd0;
            2: return 31'($urandom_range(0, 1 << 17));
            default: return 31'($urandom());
        endcase
    endfunction

    task automatic send_item(input item_t it, input bit use_gap);
        int gap;
        gap = use_gap ? (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8)) : 0;
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        @(posedge clk);
        while (item_stall) @(posedge clk);
        sb.note_item(it);
        @(negedge clk);
    endtask

    task automatic drain_results();
        item_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
    endtask

    task automatic send_directed();
        item_t it;
        logic [31:0] ext[4];
        ext[0] = 32'h7FFFFFFF;
        ext[1] = 32'h80000000;
        ext[2] = 32'd0;
        ext[3] = 32'hFFFFFFFF;
        for (int i = 0; i < 4; i++)
        begin
            it = '0;
            it.pos_x = ext[i];
            it.pos_y = ext[3 - i];
            it.pos_z = ext[i];
            it.vel_x = ext[(i + 1) % 4];
            it.vel_y = ext[(i + 2) % 4];
            it.vel_z = ext[3 - i];
            it.elapsed = (i % 2) ? 31'h7FFFFFFF : 31'h00010000;
            it.lifetime = (i < 2) ? 31'h7FFFFFFF : 31'd0;
            send_item(it, 0);
        end
        // zero swirl vector
        it = '0;
        it.lifetime = 31'h7FFFFFFF;
        send_item(it, 0);
        it.vel_x = 32'h00010000;
        it.elapsed = 31'h00010000;
        send_item(it, 0);
        // tiny swirl vector with rounding
        it = '0;
        it.pos_y = 32'd1;
        it.pos_x = 32'hFFFFFFFE;
        it.pos_z = 32'hFFFFFFFA;
        it.lifetime = 31'h00A00000;
        send_item(it, 0);
        for (int i = 0; i < 8; i++)
        begin
            it.pos_x = rand_word();
            it.pos_y = rand_word();
            it.pos_z = rand_word();
            it.vel_x = rand_word();
            it.vel_y = rand_word();
            it.vel_z = rand_word();
            it.elapsed = rand_half();
            it.lifetime = rand_half();
            send_item(it, 0);
        end
    endtask

    initial
    begin
        item_t it;
        sb = new();
        cycles = 0;
        long_holdoff = 0;
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        send_directed();
        drain_results();
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == 150)
                long_holdoff = 1;
            if (n == 300)
                drain_results();
            it.pos_x = rand_word();
            it.pos_y = rand_word();
            it.pos_z = rand_word();
            it.vel_x = rand_word();
            it.vel_y = rand_word();
            it.vel_z = rand_word();
            it.elapsed = rand_half();
            it.lifetime = rand_half();
            send_item(it, (n < 150 || n > 200) && !(n >= 320 && n < 360));
        end
        drain_results();
        repeat (LATENCY + 10) @(negedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
